FILE: rtl/ilbf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilbf_pkg
// Shared widths, codes and controller/datapath structs of the best-fit
// word heap allocator.
// ----------------------------------------------------------------------------
package ilbf_pkg;

    localparam int DEF_HEAP_WORDS = 128;

    localparam int KIND_W   = 2;
    localparam int SIZE_W   = 7;
    localparam int ADDR_W   = 7;
    localparam int WORD_W   = 8;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 8;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd3;

    // result status
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOFIT    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BADFREE  = 2'd2;

    // datapath operations
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_IDLE    = 4'd0;
    localparam logic [OP_W-1:0] OP_CAPTURE = 4'd1;
    localparam logic [OP_W-1:0] OP_START   = 4'd2;
    localparam logic [OP_W-1:0] OP_AWALK   = 4'd3;
    localparam logic [OP_W-1:0] OP_FWALK   = 4'd4;
    localparam logic [OP_W-1:0] OP_RD      = 4'd5;
    localparam logic [OP_W-1:0] OP_WR      = 4'd6;
    localparam logic [OP_W-1:0] OP_AW1     = 4'd7;
    localparam logic [OP_W-1:0] OP_AW2     = 4'd8;
    localparam logic [OP_W-1:0] OP_FMERGE  = 4'd9;
    localparam logic [OP_W-1:0] OP_FZERO   = 4'd10;

    // result staging selects
    localparam int RES_W = 3;
    localparam logic [RES_W-1:0] RES_NONE    = 3'd0;
    localparam logic [RES_W-1:0] RES_OK      = 3'd1;
    localparam logic [RES_W-1:0] RES_NOFIT   = 3'd2;
    localparam logic [RES_W-1:0] RES_BADFREE = 3'd3;
    localparam logic [RES_W-1:0] RES_GRANT   = 3'd4;
    localparam logic [RES_W-1:0] RES_RDATA   = 3'd5;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [RES_W-1:0] res;
        logic             out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              addr_zero;
        logic              addr_in_range;
        logic              walk_end;
        logic              found;
        logic              exact;
        logic              f_fail;
        logic              f_hit;
        logic              zdone;
    } t_dp_status;

endpackage

FILE: rtl/ilbf_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilbf_req_if
// Request channel: valid/ready with kind, size, address and value.
// ----------------------------------------------------------------------------
interface ilbf_req_if;
    logic                          valid;
    logic                          ready;
    logic [ilbf_pkg::KIND_W-1:0]   kind;
    logic [ilbf_pkg::SIZE_W-1:0]   size;
    logic [ilbf_pkg::ADDR_W-1:0]   address;
    logic [ilbf_pkg::WORD_W-1:0]   value;

    modport source (output valid, kind, size, address, value, input ready);
    modport sink   (input valid, kind, size, address, value, output ready);
endinterface

FILE: rtl/ilbf_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilbf_rsp_if
// Response channel: valid/ready with status, payload address and read data.
// ----------------------------------------------------------------------------
interface ilbf_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [ilbf_pkg::STATUS_W-1:0] status;
    logic [ilbf_pkg::ADDR_W-1:0]   payload_address;
    logic [ilbf_pkg::WORD_W-1:0]   read_data;

    modport source (output valid, status, payload_address, read_data, input ready);
    modport sink   (input valid, status, payload_address, read_data, output ready);
endinterface

FILE: rtl/ilbf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilbf_datapath
// Heap memory with per-word valid bits, header walk registers, block
// write-back, result staging and the output register.
// ----------------------------------------------------------------------------
module ilbf_datapath #(
    parameter int HEAP_WORDS = ilbf_pkg::DEF_HEAP_WORDS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ilbf_pkg::t_dp_cmd               i_cmd,
    output ilbf_pkg::t_dp_status            o_stat,
    input  logic [ilbf_pkg::KIND_W-1:0]     i_kind,
    input  logic [ilbf_pkg::SIZE_W-1:0]     i_size,
    input  logic [ilbf_pkg::ADDR_W-1:0]     i_address,
    input  logic [ilbf_pkg::WORD_W-1:0]     i_value,
    output logic [ilbf_pkg::STATUS_W-1:0]   o_status,
    output logic [ilbf_pkg::ADDR_W-1:0]     o_payload_address,
    output logic [ilbf_pkg::WORD_W-1:0]     o_read_data
);

    localparam int IW = $clog2(HEAP_WORDS);
    localparam logic [ilbf_pkg::POS_W-1:0] REGION_END = ilbf_pkg::POS_W'(HEAP_WORDS - 1);
    localparam logic [ilbf_pkg::POS_W-1:0] HEAP_LIM   = ilbf_pkg::POS_W'(HEAP_WORDS);
    localparam logic [ilbf_pkg::WORD_W-1:0] RST_WORD0 =
        ilbf_pkg::WORD_W'((HEAP_WORDS - 1) * 2);

    // heap store
    logic [ilbf_pkg::WORD_W-1:0] r_mem [HEAP_WORDS];
    logic                        r_vld [HEAP_WORDS];
    logic [ilbf_pkg::WORD_W-1:0] r_rdata;
    logic                        r_rvld;
    logic [IW-1:0]               r_raddr;

    // captured request
    logic [ilbf_pkg::KIND_W-1:0] r_kind;
    logic [ilbf_pkg::SIZE_W-1:0] r_size;
    logic [ilbf_pkg::ADDR_W-1:0] r_addr;
    logic [ilbf_pkg::WORD_W-1:0] r_value;

    // walk state
    logic [ilbf_pkg::POS_W-1:0]  r_pos;
    logic [ilbf_pkg::POS_W-1:0]  r_best;
    logic [ilbf_pkg::POS_W-1:0]  r_best_len;
    logic                        r_found;
    logic [ilbf_pkg::POS_W-1:0]  r_len;
    logic [ilbf_pkg::POS_W-1:0]  r_zptr;
    logic [ilbf_pkg::POS_W-1:0]  r_zend;

    // result staging and output register
    logic [ilbf_pkg::STATUS_W-1:0] r_st_status;
    logic [ilbf_pkg::ADDR_W-1:0]   r_st_paddr;
    logic [ilbf_pkg::WORD_W-1:0]   r_st_rdata;
    logic [ilbf_pkg::STATUS_W-1:0] r_o_status;
    logic [ilbf_pkg::ADDR_W-1:0]   r_o_paddr;
    logic [ilbf_pkg::WORD_W-1:0]   r_o_rdata;

    logic [ilbf_pkg::WORD_W-1:0] w_word;
    logic [ilbf_pkg::POS_W-1:0]  w_len;
    logic [ilbf_pkg::POS_W-1:0]  w_sum;
    logic [ilbf_pkg::POS_W-1:0]  w_blen;
    logic                        w_blk_ok;
    logic [ilbf_pkg::POS_W-1:0]  w_need;
    logic [ilbf_pkg::POS_W-1:0]  w_rem;
    logic [ilbf_pkg::POS_W-1:0]  w_hdr;
    logic                        w_cand;
    logic                        w_f_fail;
    logic                        w_f_hit;
    logic [ilbf_pkg::POS_W-1:0]  w_merged;
    logic                        w_zdone;

    logic                        rd_en;
    logic [IW-1:0]               rd_addr;
    logic                        wr_en;
    logic [IW-1:0]               wr_addr;
    logic [ilbf_pkg::WORD_W-1:0] wr_data;

    // a word never written still holds its reset value
    assign w_word = r_rvld ? r_rdata : ((r_raddr == '0) ? RST_WORD0 : '0);
    assign w_len  = {1'b0, w_word[ilbf_pkg::WORD_W-1:1]};
    assign w_sum  = r_pos + w_len;
    assign w_blk_ok = (r_pos < REGION_END) && (w_len != '0) && (w_sum <= REGION_END);
    assign w_blen = w_blk_ok ? w_len : '0;
    assign w_need = {1'b0, r_size} + 8'd1;
    assign w_rem  = r_best_len - w_need;
    assign w_hdr  = {1'b0, r_addr} - 8'd1;

    assign w_cand = w_blk_ok && !w_word[0] && (w_len >= w_need)
                    && (!r_found || (w_len < r_best_len));
    assign w_f_fail = !w_blk_ok || (r_pos > w_hdr) || ((r_pos == w_hdr) && !w_word[0]);
    assign w_f_hit  = w_blk_ok && (r_pos == w_hdr) && w_word[0];
    // merge only with a walkable free block that follows
    assign w_merged = r_len + ((w_blk_ok && !w_word[0]) ? w_blen : '0);
    assign w_zdone  = (r_zptr >= r_zend);

    always_comb begin
        o_stat.kind          = r_kind;
        o_stat.addr_zero     = (r_addr == '0);
        o_stat.addr_in_range = ({1'b0, r_addr} < HEAP_LIM);
        o_stat.walk_end      = !w_blk_ok;
        o_stat.found         = r_found;
        o_stat.exact         = (r_best_len == w_need);
        o_stat.f_fail        = w_f_fail;
        o_stat.f_hit         = w_f_hit;
        o_stat.zdone         = w_zdone;
    end

    // memory port control
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = w_sum[IW-1:0];
        wr_en   = 1'b0;
        wr_addr = r_best[IW-1:0];
        wr_data = '0;
        unique case (i_cmd.op)
            ilbf_pkg::OP_START: begin
                rd_en   = 1'b1;
                rd_addr = '0;
            end
            ilbf_pkg::OP_AWALK, ilbf_pkg::OP_FWALK: begin
                rd_en = 1'b1;
            end
            ilbf_pkg::OP_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_addr[IW-1:0];
            end
            ilbf_pkg::OP_WR: begin
                wr_en   = ({1'b0, r_addr} < HEAP_LIM);
                wr_addr = r_addr[IW-1:0];
                wr_data = r_value;
            end
            ilbf_pkg::OP_AW1: begin
                wr_en   = 1'b1;
                wr_data = {w_need[ilbf_pkg::WORD_W-2:0], 1'b1};
            end
            ilbf_pkg::OP_AW2: begin
                // remainder header just past the granted block
                wr_en   = 1'b1;
                wr_addr = r_best[IW-1:0] + w_need[IW-1:0];
                wr_data = {w_rem[ilbf_pkg::WORD_W-2:0], 1'b0};
            end
            ilbf_pkg::OP_FMERGE: begin
                wr_en   = 1'b1;
                wr_addr = w_hdr[IW-1:0];
                wr_data = {w_merged[ilbf_pkg::WORD_W-2:0], 1'b0};
            end
            ilbf_pkg::OP_FZERO: begin
                wr_en   = !w_zdone;
                wr_addr = r_zptr[IW-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
            r_rvld  <= r_vld[rd_addr];
            r_raddr <= rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HEAP_WORDS; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (wr_en) begin
            r_vld[wr_addr] <= 1'b1;
        end
    end

    // walk and request registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            ilbf_pkg::OP_CAPTURE: begin
                r_kind  <= i_kind;
                r_size  <= i_size;
                r_addr  <= i_address;
                r_value <= i_value;
            end
            ilbf_pkg::OP_START: begin
                r_pos   <= '0;
                r_found <= 1'b0;
            end
            ilbf_pkg::OP_AWALK: begin
                if (w_cand) begin
                    r_found    <= 1'b1;
                    r_best     <= r_pos;
                    r_best_len <= w_len;
                end
                if (w_blk_ok) begin
                    r_pos <= w_sum;
                end
            end
            ilbf_pkg::OP_FWALK: begin
                if (w_blk_ok) begin
                    r_pos <= w_sum;
                end
                if (w_f_hit) begin
                    r_len <= w_blen;
                end
            end
            ilbf_pkg::OP_FMERGE: begin
                r_zptr <= w_hdr + 8'd1;
                r_zend <= w_hdr + w_merged;
            end
            ilbf_pkg::OP_FZERO: begin
                if (!w_zdone) begin
                    r_zptr <= r_zptr + 8'd1;
                end
            end
            default: begin
            end
        endcase
    end

    // result staging
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.res)
            ilbf_pkg::RES_NONE: begin
            end
            ilbf_pkg::RES_OK: begin
                r_st_status <= ilbf_pkg::ST_OK;
                r_st_paddr  <= '0;
                r_st_rdata  <= '0;
            end
            ilbf_pkg::RES_NOFIT: begin
                r_st_status <= ilbf_pkg::ST_NOFIT;
                r_st_paddr  <= '0;
                r_st_rdata  <= '0;
            end
            ilbf_pkg::RES_BADFREE: begin
                r_st_status <= ilbf_pkg::ST_BADFREE;
                r_st_paddr  <= '0;
                r_st_rdata  <= '0;
            end
            ilbf_pkg::RES_GRANT: begin
                r_st_status <= ilbf_pkg::ST_OK;
                r_st_paddr  <= r_best[ilbf_pkg::ADDR_W-1:0] + 7'd1;
                r_st_rdata  <= '0;
            end
            ilbf_pkg::RES_RDATA: begin
                r_st_status <= ilbf_pkg::ST_OK;
                r_st_paddr  <= '0;
                r_st_rdata  <= w_word;
            end
            default: begin
            end
        endcase
        if (i_cmd.out_load) begin
            r_o_status <= r_st_status;
            r_o_paddr  <= r_st_paddr;
            r_o_rdata  <= r_st_rdata;
        end
    end

    assign o_status          = r_o_status;
    assign o_payload_address = r_o_paddr;
    assign o_read_data       = r_o_rdata;

    a_aw1_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == ilbf_pkg::OP_AW1) |-> (r_found && (r_best_len >= w_need)))
        else $error("allocate write-back without a fitting block");

    a_zero_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == ilbf_pkg::OP_FZERO) |-> (r_zptr <= r_zend))
        else $error("payload clear ran past the block");

    a_walk_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == ilbf_pkg::OP_AWALK) |=> (r_pos <= REGION_END))
        else $error("header walk left the block region");

endmodule

FILE: rtl/ilbf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilbf_ctrl
// Sequencer for allocate, free, read and write requests, plus the
// request/response handshake.
// ----------------------------------------------------------------------------
module ilbf_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output ilbf_pkg::t_dp_cmd    o_cmd,
    input  ilbf_pkg::t_dp_status i_stat
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_AWALK    = 4'd2;
    localparam logic [3:0] S_AW1      = 4'd3;
    localparam logic [3:0] S_AW2      = 4'd4;
    localparam logic [3:0] S_FWALK    = 4'd5;
    localparam logic [3:0] S_FMERGE   = 4'd6;
    localparam logic [3:0] S_FZERO    = 4'd7;
    localparam logic [3:0] S_RDATA    = 4'd8;
    localparam logic [3:0] S_FIN      = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state        = r_state;
        o_cmd.op       = ilbf_pkg::OP_IDLE;
        o_cmd.res      = ilbf_pkg::RES_NONE;
        o_cmd.out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = ilbf_pkg::OP_CAPTURE;
                    n_state  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (i_stat.kind)
                    ilbf_pkg::KIND_ALLOC: begin
                        o_cmd.op = ilbf_pkg::OP_START;
                        n_state  = S_AWALK;
                    end
                    ilbf_pkg::KIND_FREE: begin
                        if (i_stat.addr_zero) begin
                            o_cmd.res = ilbf_pkg::RES_BADFREE;
                            n_state   = S_FIN;
                        end else begin
                            o_cmd.op = ilbf_pkg::OP_START;
                            n_state  = S_FWALK;
                        end
                    end
                    ilbf_pkg::KIND_READ: begin
                        if (i_stat.addr_in_range) begin
                            o_cmd.op = ilbf_pkg::OP_RD;
                            n_state  = S_RDATA;
                        end else begin
                            o_cmd.res = ilbf_pkg::RES_OK;
                            n_state   = S_FIN;
                        end
                    end
                    ilbf_pkg::KIND_WRITE: begin
                        o_cmd.op  = ilbf_pkg::OP_WR;
                        o_cmd.res = ilbf_pkg::RES_OK;
                        n_state   = S_FIN;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_AWALK: begin
                o_cmd.op = ilbf_pkg::OP_AWALK;
                if (i_stat.walk_end) begin
                    if (i_stat.found) begin
                        n_state = S_AW1;
                    end else begin
                        o_cmd.res = ilbf_pkg::RES_NOFIT;
                        n_state   = S_FIN;
                    end
                end
            end
            S_AW1: begin
                o_cmd.op = ilbf_pkg::OP_AW1;
                if (i_stat.exact) begin
                    o_cmd.res = ilbf_pkg::RES_GRANT;
                    n_state   = S_FIN;
                end else begin
                    n_state = S_AW2;
                end
            end
            S_AW2: begin
                o_cmd.op  = ilbf_pkg::OP_AW2;
                o_cmd.res = ilbf_pkg::RES_GRANT;
                n_state   = S_FIN;
            end
            S_FWALK: begin
                o_cmd.op = ilbf_pkg::OP_FWALK;
                if (i_stat.f_fail) begin
                    o_cmd.res = ilbf_pkg::RES_BADFREE;
                    n_state   = S_FIN;
                end else if (i_stat.f_hit) begin
                    n_state = S_FMERGE;
                end
            end
            S_FMERGE: begin
                o_cmd.op = ilbf_pkg::OP_FMERGE;
                n_state  = S_FZERO;
            end
            S_FZERO: begin
                o_cmd.op = ilbf_pkg::OP_FZERO;
                if (i_stat.zdone) begin
                    o_cmd.res = ilbf_pkg::RES_OK;
                    n_state   = S_FIN;
                end
            end
            S_RDATA: begin
                o_cmd.res = ilbf_pkg::RES_RDATA;
                n_state   = S_FIN;
            end
            S_FIN: begin
                // wait for the output register to drain
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_fin_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && (!r_out_valid || i_out_ready)) |=> (r_out_valid && r_state == S_IDLE))
        else $error("finished result not moved into the output register");

    a_accept_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_DISPATCH && !o_in_ready))
        else $error("accepted beat not dispatched");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("response beat dropped before it was taken");

endmodule

FILE: rtl/implicit_list_best_fit_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// implicit_list_best_fit_allocator
// Best-fit word heap over an implicit header list: allocate, free with
// forward merge, read word and write word.
// ----------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  i_req     in   valid/ready   kind, size, address, value
//  o_rsp     out  valid/ready   status, payload_address, read_data
//
//  Write and read address one heap word. Allocate walks every header (end
//  one included), writes the granted header on a fit and a remainder
//  header on split; free walks headers up to the block, then merges
//  forward and clears the payload: one header or one cleared word a cycle.
//  Reset: per-word valid bits clear at once; no clearing pass over the heap.
//  One result waits in the output register while the next beat is taken; a
//  finished beat holds until that register drains.
// ----------------------------------------------------------------------------
module implicit_list_best_fit_allocator #(
    parameter int HEAP_WORDS = ilbf_pkg::DEF_HEAP_WORDS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ilbf_req_if.sink    i_req,
    ilbf_rsp_if.source  o_rsp
);

    ilbf_pkg::t_dp_cmd    cmd;
    ilbf_pkg::t_dp_status stat;

    ilbf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    ilbf_datapath #(
        .HEAP_WORDS (HEAP_WORDS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_kind            (i_req.kind),
        .i_size            (i_req.size),
        .i_address         (i_req.address),
        .i_value           (i_req.value),
        .o_status          (o_rsp.status),
        .o_payload_address (o_rsp.payload_address),
        .o_read_data       (o_rsp.read_data)
    );

endmodule
